// File: hdl/vcfe_pkg.sv
`default_nettype none

package vcfe_pkg;

	localparam int KIND_W      = 3;
	localparam int VALUE_W     = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 8;
	localparam int IDX_W       = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_CHANNEL = 3'd0,
		KIND_SET_FREQ    = 3'd1,
		KIND_SET_POWER   = 3'd2,
		KIND_SET_MW      = 3'd3,
		KIND_REQUEST     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		FMT_REJECT = 2'd0,
		FMT_SHORT  = 2'd1,
		FMT_REQ    = 2'd2,
		FMT_LONG   = 2'd3
	} fmt_t;

	localparam logic [7:0] CRC_POLY     = 8'hD5;
	localparam logic [7:0] SYNC_0       = 8'hAA;
	localparam logic [7:0] SYNC_1       = 8'h55;
	localparam logic [7:0] CMD_CHANNEL  = 8'h07;
	localparam logic [7:0] CMD_FREQ     = 8'h09;
	localparam logic [7:0] CMD_POWER    = 8'h05;
	localparam logic [7:0] CMD_REQUEST  = 8'h03;
	localparam logic [7:0] REQ_CRC      = 8'h9F;
	localparam logic [7:0] LONG_HEAD    = 8'h0F;
	localparam logic [7:0] LETTER_FREQ  = 8'h46;
	localparam logic [7:0] LETTER_MW    = 8'h50;
	localparam logic [7:0] LETTER_REQ   = 8'h72;

	localparam logic [IDX_W-1:0] LONG_SUM_IDX = 4'd14;
	localparam logic [IDX_W-1:0] LONG_LAST    = 4'd15;

	typedef struct packed {
		fmt_t             fmt;
		logic [7:0]       cmd;
		logic [7:0]       len;
		logic [7:0]       p0;
		logic [7:0]       p1;
		logic [7:0]       sum;
		logic [IDX_W-1:0] last_idx;
	} desc_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/vcfe_front.sv
`default_nettype none

module vcfe_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire                                cfg_wdata,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [vcfe_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire                                q_full,
	output logic                               q_push,
	output vcfe_pkg::desc_t                    q_desc
);
	import vcfe_pkg::*;

	logic               mode_q;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] value;
	logic [7:0]         lo;
	logic [7:0]         hi;
	logic               wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign kind  = s_tdata[KIND_W-1:0];
	assign value = s_tdata[KIND_W +: VALUE_W];
	assign lo    = value[7:0];
	assign hi    = value[15:8];
	assign wide  = |hi;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_desc          = '0;
		q_desc.fmt      = FMT_REJECT;
		q_desc.last_idx = '0;
		if (!mode_q) begin
			case (kind)
				KIND_SET_CHANNEL: begin
					if (!wide) begin
						q_desc.fmt      = FMT_SHORT;
						q_desc.cmd      = CMD_CHANNEL;
						q_desc.len      = 8'd1;
						q_desc.p0       = lo;
						q_desc.last_idx = 4'd6;
					end
				end
				KIND_SET_FREQ: begin
					q_desc.fmt      = FMT_SHORT;
					q_desc.cmd      = CMD_FREQ;
					q_desc.len      = 8'd2;
					q_desc.p0       = hi;
					q_desc.p1       = lo;
					q_desc.last_idx = 4'd7;
				end
				KIND_SET_POWER: begin
					if (!wide) begin
						q_desc.fmt      = FMT_SHORT;
						q_desc.cmd      = CMD_POWER;
						q_desc.len      = 8'd1;
						q_desc.p0       = lo;
						q_desc.last_idx = 4'd6;
					end
				end
				KIND_REQUEST: begin
					q_desc.fmt      = FMT_REQ;
					q_desc.cmd      = CMD_REQUEST;
					q_desc.len      = 8'd0;
					q_desc.last_idx = 4'd5;
				end
				default: ;
			endcase
		end else begin
			case (kind)
				KIND_SET_FREQ: begin
					q_desc.fmt      = FMT_LONG;
					q_desc.cmd      = LETTER_FREQ;
					q_desc.p0       = lo;
					q_desc.p1       = hi;
					q_desc.last_idx = LONG_LAST;
				end
				KIND_SET_MW: begin
					q_desc.fmt      = FMT_LONG;
					q_desc.cmd      = LETTER_MW;
					q_desc.p0       = lo;
					q_desc.p1       = hi;
					q_desc.last_idx = LONG_LAST;
				end
				KIND_REQUEST: begin
					q_desc.fmt      = FMT_LONG;
					q_desc.cmd      = LETTER_REQ;
					q_desc.last_idx = LONG_LAST;
				end
				default: ;
			endcase
		end
		q_desc.sum = q_desc.cmd + q_desc.p0 + q_desc.p1;
	end

endmodule

`default_nettype wire

// File: hdl/vcfe_queue.sv
`default_nettype none

module vcfe_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  vcfe_pkg::desc_t  push_desc,
	output logic             full,
	input  wire              pop,
	output logic             head_valid,
	output vcfe_pkg::desc_t  head_desc
);
	import vcfe_pkg::*;

	desc_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/vcfe_back.sv
`default_nettype none

module vcfe_back (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 head_valid,
	input  vcfe_pkg::desc_t                     head_desc,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [vcfe_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast,
	output logic                                m_tuser
);
	import vcfe_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       crc_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             rej_q;
	logic             load;
	logic             is_last;
	logic [7:0]       cur_byte;

	assign load    = head_valid && (!valid_q || m_tready);
	assign is_last = (head_desc.fmt == FMT_REJECT) || (idx_q == head_desc.last_idx);
	assign pop     = load && is_last;

	always_comb begin
		cur_byte = 8'h00;
		case (head_desc.fmt)
			FMT_SHORT, FMT_REQ: begin
				if (is_last) begin
					cur_byte = (head_desc.fmt == FMT_REQ) ? REQ_CRC : crc_q;
				end else begin
					case (idx_q)
						4'd1:    cur_byte = SYNC_0;
						4'd2:    cur_byte = SYNC_1;
						4'd3:    cur_byte = head_desc.cmd;
						4'd4:    cur_byte = head_desc.len;
						4'd5:    cur_byte = head_desc.p0;
						4'd6:    cur_byte = head_desc.p1;
						default: cur_byte = 8'h00;
					endcase
				end
			end
			FMT_LONG: begin
				case (idx_q)
					4'd0:         cur_byte = LONG_HEAD;
					4'd1:         cur_byte = head_desc.cmd;
					4'd2:         cur_byte = head_desc.p0;
					4'd3:         cur_byte = head_desc.p1;
					LONG_SUM_IDX: cur_byte = head_desc.sum;
					default:      cur_byte = 8'h00;
				endcase
			end
			default: cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// crc runs over bytes 1 .. n-2
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= is_last;
			rej_q  <= (head_desc.fmt == FMT_REJECT);
			if (idx_q == '0) begin
				crc_q <= 8'h00;
			end else if (!is_last) begin
				crc_q <= crc8_byte(crc_q, cur_byte);
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = rej_q;

endmodule

`default_nettype wire

// File: hdl/vtx_command_frame_encoder.sv
// A request's first byte passes through the request queue and the output register.
// Throughput: one frame byte per cycle while the receiver accepts; a frame is 6 to 16
// bytes long (16 in checksum mode), a rejection a single byte. A two-entry request
// queue lets the input take new requests while a frame is still going out.
// Reset: arst_n clears the mode register to CRC framing and empties queue and output.
`default_nettype none

module vtx_command_frame_encoder (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire                                cfg_wdata,      // protocol_mode
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [vcfe_pkg::IN_TDATA_W-1:0]    s_tdata,        // kind[2:0], value[18:3]
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [vcfe_pkg::OUT_TDATA_W-1:0]   m_tdata,        // frame_byte[7:0]
	output logic                               m_tlast,
	output logic                               m_tuser         // rejected
);
	import vcfe_pkg::*;

	logic  q_full;
	logic  q_push;
	desc_t q_desc;
	logic  head_valid;
	desc_t head_desc;
	logic  pop;

	vcfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	vcfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	vcfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

// File: hdl/vcfe_checker.sv
`default_nettype none

module vcfe_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [vcfe_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input wire                              m_tlast,
	input wire                              m_tuser
);
	import vcfe_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output request changed while stalled");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("rejection not a single zero last byte");

	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> !m_tuser)
		else $error("rejection inside a frame");

endmodule

bind vtx_command_frame_encoder vcfe_checker u_vcfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: verif/tb_vtx_command_frame_encoder.sv
`default_nettype none

module tb_vtx_command_frame_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import vcfe_pkg::*;

	localparam logic             MODE_CRC          = 1'b0;
	localparam logic             MODE_SUM          = 1'b1;
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
	localparam int               PAD_W             = IN_TDATA_W - KIND_W - VALUE_W;
	localparam longint           CYCLE_LIMIT       = 1_500_000;
	localparam int               PHASE_ITEMS       = 75;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
	} vtx_cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       rejected;
	} frame_byte_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;

	vtx_command_frame_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	vtx_cmd_t    cmd_backlog[$];
	frame_byte_t frame_due[$];
	vtx_cmd_t    cmd_on_bus;
	logic        mode_copy = MODE_CRC;
	bit          quiet     = 1'b0;
	int          errors    = 0;
	longint      cycles    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// expected bytes of the frame for one request under the current mode
	function automatic void predict_frame(vtx_cmd_t c);
		logic [7:0] fb[16];
		logic [7:0] acc;
		int         n;
		bit         reject;
		frame_byte_t e;
		n = 0;
		reject = 1'b0;
		acc = '0;
		for (int i = 0; i < 16; i++)
			fb[i] = '0;
		if (mode_copy == MODE_CRC) begin
			fb[1] = SYNC_0;
			fb[2] = SYNC_1;
			case (c.kind)
				KIND_SET_CHANNEL, KIND_SET_POWER: begin
					if (c.value > 16'd255) begin
						reject = 1'b1;
					end else begin
						fb[3] = (c.kind == KIND_SET_CHANNEL) ? CMD_CHANNEL : CMD_POWER;
						fb[4] = 8'h01;
						fb[5] = c.value[7:0];
						n = 7;
					end
				end
				KIND_SET_FREQ: begin
					fb[3] = CMD_FREQ;
					fb[4] = 8'h02;
					fb[5] = c.value[15:8];
					fb[6] = c.value[7:0];
					n = 8;
				end
				KIND_REQUEST: begin
					fb[3] = CMD_REQUEST;
					fb[4] = 8'h00;
					fb[5] = REQ_CRC;
					n = 6;
				end
				default: reject = 1'b1;
			endcase
			if (!reject && c.kind != KIND_REQUEST) begin
				for (int i = 1; i < n - 1; i++) begin
					acc = acc ^ fb[i];
					for (int b = 0; b < 8; b++)
						acc = acc[7] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
				end
				fb[n-1] = acc;
			end
		end else begin
			fb[0] = LONG_HEAD;
			case (c.kind)
				KIND_SET_FREQ: begin
					fb[1] = LETTER_FREQ;
					fb[2] = c.value[7:0];
					fb[3] = c.value[15:8];
				end
				KIND_SET_MW: begin
					fb[1] = LETTER_MW;
					fb[2] = c.value[7:0];
					fb[3] = c.value[15:8];
				end
				KIND_REQUEST: fb[1] = LETTER_REQ;
				default: reject = 1'b1;
			endcase
			n = 16;
			for (int i = 1; i < 14; i++)
				acc = acc + fb[i];
			fb[14] = acc;
		end
		if (reject) begin
			e.data = '0;
			e.last = 1'b1;
			e.rejected = 1'b1;
			frame_due.push_back(e);
		end else begin
			for (int k = 0; k < n; k++) begin
				e.data = fb[k];
				e.last = (k == n - 1);
				e.rejected = 1'b0;
				frame_due.push_back(e);
			end
		end
	endfunction

	// request driver
	always @(posedge clk) begin : req_driver
		int unsigned gap;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_frame(cmd_on_bus);
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd_on_bus = cmd_backlog.pop_front();
					s_tdata <= {{PAD_W{1'b0}}, cmd_on_bus.value, cmd_on_bus.kind};
					s_tvalid <= 1'b1;
					gap = quiet ? 0 : gap_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end else begin
			gap = 0;
		end
	end

	// receiver: random stalls plus one long hold-off to back the block up
	always @(posedge clk) begin : byte_sink
		int unsigned stall;
		int unsigned hold;
		int unsigned taken;
		bit          hold_done;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				taken++;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!hold_done && taken >= 400) begin
				hold_done = 1'b1;
				hold = 250;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = quiet ? 0 : gap_len();
				m_tready <= (stall == 0);
			end
		end else begin
			stall = 0;
			hold = 0;
			taken = 0;
			hold_done = 1'b0;
		end
	end

	always @(posedge clk) begin : byte_check
		frame_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_due.size() == 0) begin
				$error("unexpected frame byte %02h last %0b rejected %0b",
					m_tdata, m_tlast, m_tuser);
				errors++;
			end else begin
				want = frame_due.pop_front();
				if (m_tdata !== want.data) begin
					$error("frame_byte: expected %02h, got %02h", want.data, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
				if (m_tuser !== want.rejected) begin
					$error("rejected: expected %0b, got %0b", want.rejected, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk)
		cycles++;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic add_cmd(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
		vtx_cmd_t c;
		c.kind = k;
		c.value = v;
		cmd_backlog.push_back(c);
	endtask

	task automatic add_random_cmds(input int count);
		int unsigned r;
		logic [KIND_W-1:0]  k;
		logic [VALUE_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			k = (r < 18) ? KIND_W'(r % 5) : KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			r = $urandom_range(0, 9);
			if (r < 4)
				v = VALUE_W'($urandom_range(0, 255));
			else if (r == 4)
				case ($urandom_range(0, 3))
					0: v = 16'd0;
					1: v = 16'd255;
					2: v = 16'd256;
					default: v = 16'hFFFF;
				endcase
			else
				v = VALUE_W'($urandom_range(0, 65535));
			add_cmd(k, v);
		end
	endtask

	// settled values are read between edges
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() > 0 || s_tvalid || frame_due.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		mode_copy = m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// CRC framing straight out of reset
		add_cmd(KIND_SET_CHANNEL, 16'd0);
		add_cmd(KIND_SET_CHANNEL, 16'd255);
		add_cmd(KIND_SET_CHANNEL, 16'd256);
		add_cmd(KIND_SET_CHANNEL, 16'hFFFF);
		add_cmd(KIND_SET_FREQ, 16'd0);
		add_cmd(KIND_SET_FREQ, 16'hFFFF);
		add_cmd(KIND_SET_FREQ, 16'd5800);
		add_cmd(KIND_SET_POWER, 16'd0);
		add_cmd(KIND_SET_POWER, 16'd255);
		add_cmd(KIND_SET_POWER, 16'd256);
		add_cmd(KIND_SET_MW, 16'd25);
		add_cmd(KIND_REQUEST, 16'hFFFF);
		add_cmd(KIND_SPARE_FIRST, 16'd1);
		add_cmd(KIND_SPARE_LAST, 16'hAAAA);
		set_mode(MODE_SUM);
		add_cmd(KIND_SET_FREQ, 16'd0);
		add_cmd(KIND_SET_FREQ, 16'hFFFF);
		add_cmd(KIND_SET_MW, 16'h5555);
		add_cmd(KIND_SET_MW, 16'hFFFF);
		add_cmd(KIND_REQUEST, 16'h1234);
		add_cmd(KIND_SET_CHANNEL, 16'd5);
		add_cmd(KIND_SET_POWER, 16'd5);
		add_cmd(KIND_SPARE_FIRST, 16'd0);
		add_cmd(KIND_SPARE_LAST, 16'hFFFF);

		for (int p = 0; p < 6; p++) begin
			set_mode((p % 2) ? MODE_SUM : MODE_CRC);
			quiet = (p == 2);
			add_random_cmds(PHASE_ITEMS);
		end
		drain();
		repeat (16) @(posedge clk);
		if (errors == 0 && frame_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
